>>> rtl/piecewise_linear_curve_eval_top_defines.svh
`ifndef PIECEWISE_LINEAR_CURVE_EVAL_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_EVAL_TOP_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define PLCE_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define PLCE_ASSERT_IMPLIES(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

`endif

>>> rtl/plce_pkg.sv
`timescale 1ns / 1ps
package plce_pkg;

  localparam int MAX_POINTS = 16;
  localparam int VALUE_W    = 8;
  localparam int TICK_W     = 32;
  localparam int SLOT_W     = 4;
  localparam int ACTIVE_W   = 5;
  localparam int REGION_W   = 2;
  localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ENTRY_W    = TICK_W + VALUE_W;
  localparam int PROD_W     = TICK_W + VALUE_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef enum logic [REGION_W-1:0] {
    REG_DEFAULT = 2'd0,
    REG_LEFT    = 2'd1,
    REG_INTERP  = 2'd2,
    REG_RIGHT   = 2'd3
  } region_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DECIDE,
    S_MULT,
    S_START,
    S_DIV,
    S_RES
  } state_t;

endpackage

>>> rtl/plce_if.sv
`timescale 1ns / 1ps
interface plce_in_if;
  import plce_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [SLOT_W-1:0]        slot;
  logic signed [TICK_W-1:0] point_tick;
  logic [VALUE_W-1:0]       point_value;
  logic signed [TICK_W-1:0] position;

  modport source (output valid, mode, slot, point_tick, point_value, position,
                  input ready);
  modport sink   (input valid, mode, slot, point_tick, point_value, position,
                  output ready);
endinterface

interface plce_out_if;
  import plce_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  level;
  logic [REGION_W-1:0] region;

  modport source (output valid, level, region, input ready);
  modport sink   (input valid, level, region, output ready);
endinterface

interface plce_cfg_if;
  import plce_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTIVE_W-1:0] active_points;

  modport source (output valid, active_points, input ready);
  modport sink   (input valid, active_points, output ready);
endinterface

>>> rtl/plce_ram.sv
`timescale 1ns / 1ps
module plce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/plce_div.sv
`timescale 1ns / 1ps
module plce_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [plce_pkg::PROD_W-1:0]    dividend,
  input  logic [plce_pkg::TICK_W-1:0]    divisor,
  output logic                           done,
  output logic [plce_pkg::VALUE_W-1:0]   quotient
);
  import plce_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    quo;
  logic [TICK_W-1:0]    rem;
  logic [TICK_W-1:0]    dvs;
  logic [TICK_W:0]      rem_sh;
  logic [TICK_W:0]      diff;
  logic                 ge;

  // One restoring step per cycle, quotient bits shift in from the bottom.
  always_comb begin
    rem_sh = {rem, quo[PROD_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = ~diff[TICK_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(PROD_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[PROD_W-2:0], ge};
      rem <= ge ? diff[TICK_W-1:0] : rem_sh[TICK_W-1:0];
    end
  end

  assign quotient = quo[VALUE_W-1:0];
endmodule

>>> rtl/piecewise_linear_curve_eval_top.sv
// Load transaction: loads may follow back to back.
// Evaluate, n active points: none goes straight to S_RES; one point or a clamp
// scans with n table reads, then decides; interpolated adds a 40-step divider.
// Input ready again in the cycle the result goes valid, held off while output stalls.
// rst (synchronous) clears active_points and the sequencer; the point table is
// undefined until written.
`timescale 1ns / 1ps
`include "piecewise_linear_curve_eval_top_defines.svh"
module piecewise_linear_curve_eval_top (
  input  logic       clk,
  input  logic       rst,
  plce_in_if.sink    items,
  plce_out_if.source results,
  plce_cfg_if.sink   cfg
);
  import plce_pkg::*;

  state_t state, state_next;

  logic [ACTIVE_W-1:0]      active_points;
  logic [CNT_W-1:0]         n_pts;
  logic [CNT_W-1:0]         n_cur;
  logic [CNT_W-1:0]         idx;
  logic signed [TICK_W-1:0] x;
  logic                     rvalid;

  logic                     have_left, have_right;
  logic signed [TICK_W-1:0] left_tick, right_tick;
  logic [VALUE_W-1:0]       left_val, right_val;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic signed [TICK_W-1:0] rd_tick;
  logic [VALUE_W-1:0]       rd_val;
  logic                     rd_right;

  logic [VALUE_W-1:0]       da;
  logic                     neg;
  logic [PROD_W-1:0]        prod;
  logic [TICK_W-1:0]        den;
  logic signed [TICK_W:0]   dx_full, den_full;
  logic [VALUE_W-1:0]       quotient;
  logic                     div_start;
  logic                     div_done;

  logic [VALUE_W-1:0]       res_level;
  region_t                  res_region;
  logic                     out_free;
  logic                     accept;

  assign cfg.ready = 1'b1;
  assign n_pts = (int'(active_points) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                    : CNT_W'(active_points);
  assign accept   = items.valid && items.ready;
  assign out_free = !results.valid || results.ready;
  assign ram_we   = accept && (items.mode == MODE_LOAD) && (int'(items.slot) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_points <= '0;
    end else if (cfg.valid && cfg.ready) begin
      active_points <= cfg.active_points;
    end
  end

  plce_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(items.slot)),
    .wdata ({items.point_tick, items.point_value}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_tick  = ram_rdata[ENTRY_W-1:VALUE_W];
  assign rd_val   = ram_rdata[VALUE_W-1:0];
  assign rd_right = (rd_tick >= x);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (items.mode == MODE_EVAL)) begin
          state_next = (n_pts == '0) ? S_RES : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx == n_cur - 1'b1) begin
          state_next = S_LAST;
        end
      end
      S_LAST:   state_next = S_DECIDE;
      S_DECIDE: begin
        if ((n_cur != CNT_W'(1)) && have_left && have_right) begin
          state_next = S_MULT;
        end else begin
          state_next = S_RES;
        end
      end
      S_MULT:   state_next = S_START;
      S_START:  state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    items.ready = 1'b0;
    ram_raddr   = idx[ADDR_W-1:0];
    div_start   = 1'b0;
    case (state)
      S_IDLE:  items.ready = 1'b1;
      S_START: div_start   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= (state == S_SCAN);
    end
  end

  always_comb begin
    dx_full  = {x[TICK_W-1], x} - {left_tick[TICK_W-1], left_tick};
    den_full = {right_tick[TICK_W-1], right_tick} - {left_tick[TICK_W-1], left_tick};
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x          <= items.position;
        n_cur      <= n_pts;
        idx        <= '0;
        have_left  <= 1'b0;
        have_right <= 1'b0;
        res_level  <= '1;
        res_region <= REG_DEFAULT;
      end
      S_SCAN: idx <= idx + 1'b1;
      S_DECIDE: begin
        if (n_cur == CNT_W'(1)) begin
          res_level  <= have_left ? left_val : right_val;
          res_region <= REG_DEFAULT;
        end else if (!have_left) begin
          res_level  <= right_val;
          res_region <= REG_LEFT;
        end else if (!have_right) begin
          res_level  <= left_val;
          res_region <= REG_RIGHT;
        end
        neg <= (right_val < left_val);
        da  <= (right_val >= left_val) ? (right_val - left_val) : (left_val - right_val);
        den <= den_full[TICK_W-1:0];
        prod <= PROD_W'(dx_full[TICK_W-1:0]);
      end
      S_MULT: begin
        prod <= PROD_W'(da) * prod;
      end
      S_DIV: begin
        if (div_done) begin
          res_level  <= neg ? (left_val - quotient) : (left_val + quotient);
          res_region <= REG_INTERP;
        end
      end
      default: ;
    endcase

    // Track the bracketing pair; slots arrive in ascending order.
    if (rvalid) begin
      if (rd_right) begin
        if (!have_right || (rd_tick < right_tick)) begin
          have_right <= 1'b1;
          right_tick <= rd_tick;
          right_val  <= rd_val;
        end
      end else begin
        if (!have_left || (rd_tick >= left_tick)) begin
          have_left <= 1'b1;
          left_tick <= rd_tick;
          left_val  <= rd_val;
        end
      end
    end
  end

  plce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if ((state == S_RES) && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RES) && out_free) begin
      results.level  <= res_level;
      results.region <= res_region;
    end
  end

  `PLCE_ASSERT_IMPLIES(a_quot_bounded, (state == S_DIV) && div_done, quotient <= da, "interpolation step exceeds value span")
  `PLCE_ASSERT_IMPLIES(a_bracket_order, state == S_MULT, (den != '0) && (left_tick < right_tick), "bracketing pair not strictly ordered")
  `PLCE_ASSERT_IMPLIES(a_scan_range, state == S_SCAN, (idx < n_cur) && (n_cur != '0), "scan index past active points")
  `PLCE_ASSERT_IMPLIES(a_read_window, rvalid, (state == S_SCAN) || (state == S_LAST), "table data arrives outside scan")
endmodule
